/* rtl/togvf_pkg.sv */
// shared constants, command codes and controller/datapath interface types
package togvf_pkg;

  localparam int POS_W     = 24;
  localparam int TIME_W    = 48;
  localparam int VEL_W     = 32;
  localparam int CNT_W     = 8;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W      = 20;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_W     = 52;
  localparam int DEN_W     = 20;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_STEPS;

  localparam logic [DEN_W-1:0] US_PER_S  = 20'd1000000;
  localparam logic [16:0]      ALPHA_ONE = 17'd65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICT = 3'd4;

  // datapath commands
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_DT        = 5'd2;
  localparam logic [4:0] OP_AGE       = 5'd3;
  localparam logic [4:0] OP_PMUL      = 5'd4;
  localparam logic [4:0] OP_DIV_PRED  = 5'd5;
  localparam logic [4:0] OP_PDIFF     = 5'd6;
  localparam logic [4:0] OP_SQ        = 5'd7;
  localparam logic [4:0] OP_SQACC     = 5'd8;
  localparam logic [4:0] OP_AMUL      = 5'd9;
  localparam logic [4:0] OP_DIV_ALLOW = 5'd10;
  localparam logic [4:0] OP_ASET      = 5'd11;
  localparam logic [4:0] OP_ASQ       = 5'd12;
  localparam logic [4:0] OP_REJECT    = 5'd13;
  localparam logic [4:0] OP_VZERO     = 5'd14;
  localparam logic [4:0] OP_RMUL      = 5'd15;
  localparam logic [4:0] OP_DIV_RAW   = 5'd16;
  localparam logic [4:0] OP_RSET      = 5'd17;
  localparam logic [4:0] OP_ALO       = 5'd18;
  localparam logic [4:0] OP_AHI       = 5'd19;
  localparam logic [4:0] OP_AOLD      = 5'd20;
  localparam logic [4:0] OP_ASUM      = 5'd21;
  localparam logic [4:0] OP_VSET      = 5'd22;
  localparam logic [4:0] OP_ACCEPT    = 5'd23;
  localparam logic [4:0] OP_OUT       = 5'd24;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic ignore;
    logic first;
    logic long_gap;
    logic outlier;
    logic below_limit;
    logic div_busy;
  } dp_status_t;

endpackage

/* rtl/togvf_div.sv */
// iterative unsigned divider, four quotient bits per cycle
module togvf_div import togvf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [DIV_W-1:0] quot
);

  localparam int CNT_BITS = $clog2(DIV_CYCLES + 1);

  logic [DIV_W-1:0]    work;
  logic [DEN_W-1:0]    rem;
  logic [DEN_W-1:0]    den_reg;
  logic [CNT_BITS-1:0] count;
  logic [DIV_W-1:0]    work_next;
  logic [DEN_W-1:0]    rem_next;
  logic [DEN_W:0]      trial;

  always_comb begin
    work_next = work;
    rem_next  = rem;
    trial     = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial     = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_reg}) begin
        trial        = trial - {1'b0, den_reg};
        work_next[0] = 1'b1;
      end
      rem_next = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      work    <= num;
      rem     <= '0;
      den_reg <= den;
      count   <= CNT_BITS'(DIV_CYCLES);
    end else if (count != '0) begin
      work  <= work_next;
      rem   <= rem_next;
      count <= count - 1'b1;
    end
  end

  assign busy = (count != '0);
  assign quot = work;

endmodule

/* rtl/togvf_dp.sv */
// datapath: config registers, target state, multiplier, divider and output word
module togvf_dp import togvf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic signed [POS_W-1:0]  meas_x_mm,
  input  logic signed [POS_W-1:0]  meas_y_mm,
  input  logic signed [POS_W-1:0]  meas_z_mm,
  input  logic [TIME_W-1:0]        meas_time_us,
  input  logic                     meas_valid,
  output logic                     accepted,
  output logic                     outlier_rejected,
  output logic [CNT_W-1:0]         rejects_in_row,
  output logic signed [VEL_W-1:0]  vel_x_mm_s,
  output logic signed [VEL_W-1:0]  vel_y_mm_s,
  output logic signed [VEL_W-1:0]  vel_z_mm_s
);

  // configuration
  logic [15:0] margin;
  logic [15:0] speed;
  logic [7:0]  limit;
  logic [16:0] alpha;
  logic [13:0] predict_ms;

  // item and target state
  logic signed [POS_W-1:0] m  [3];
  logic signed [POS_W-1:0] lp [3];
  logic signed [VEL_W-1:0] v  [3];
  logic [TIME_W-1:0]       t;
  logic                    valid;
  logic [TIME_W-1:0]       ltime;
  logic                    have;
  logic [CNT_W-1:0]        rcnt;
  logic                    acc_flag;
  logic                    rej_flag;

  // work registers
  logic [TIME_W-1:0]        dt;
  logic [DT_W-1:0]          age;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  diff;
  logic [63:0]              innov;
  logic [16:0]              allow;
  logic signed [47:0]       raw;
  logic signed [63:0]       acc;
  logic                     q_neg;

  logic signed [POS_W-1:0] m_sel;
  logic signed [POS_W-1:0] lp_sel;
  logic signed [VEL_W-1:0] v_sel;
  logic [23:0]             lim_us;
  logic [DT_W-1:0]         age_next;
  logic [16:0]             alpha_sat;
  logic [16:0]             alpha_cmp;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic                    mul_en;
  logic signed [24:0]      step25;
  logic [PROD_W-1:0]       prod_mag;
  logic [DEN_W-1:0]        div_den;
  logic [DIV_W-1:0]        div_num;
  logic                    div_start;
  logic                    div_busy;
  logic [DIV_W-1:0]        quot;
  logic signed [DIV_W:0]   qs;
  logic signed [33:0]      pred;
  logic signed [33:0]      diff_full;
  logic [63:0]             acc_mag;
  logic [63:0]             vmag;
  logic signed [VEL_W-1:0] vnew;

  assign m_sel  = m[cmd.axis];
  assign lp_sel = lp[cmd.axis];
  assign v_sel  = v[cmd.axis];

  assign lim_us    = 24'(predict_ms) * 24'd1000;
  assign age_next  = ({4'b0, dt[DT_W-1:0]} < lim_us) ? dt[DT_W-1:0] : lim_us[DT_W-1:0];
  assign alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign alpha_cmp = ALPHA_ONE - alpha_sat;
  assign step25    = {m_sel[POS_W-1], m_sel} - {lp_sel[POS_W-1], lp_sel};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_PMUL: begin
        mul_a = {v_sel[VEL_W-1], v_sel};
        mul_b = {13'b0, age};
      end
      OP_SQ: begin
        mul_a = diff;
        mul_b = diff;
      end
      OP_AMUL: begin
        mul_a = {17'b0, speed};
        mul_b = {13'b0, dt[DT_W-1:0]};
      end
      OP_ASQ: begin
        mul_a = {16'b0, allow};
        mul_b = {16'b0, allow};
      end
      OP_RMUL: begin
        mul_a = {{8{step25[24]}}, step25};
        mul_b = {13'b0, US_PER_S};
      end
      OP_ALO: begin
        mul_a = {16'b0, alpha_sat};
        mul_b = {9'b0, raw[23:0]};
      end
      OP_AHI: begin
        mul_a = {16'b0, alpha_sat};
        mul_b = {{9{raw[47]}}, raw[47:24]};
      end
      OP_AOLD: begin
        mul_a = {16'b0, alpha_cmp};
        mul_b = {v_sel[VEL_W-1], v_sel};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // divider operands
  assign prod_mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign div_den   = (cmd.op == OP_DIV_RAW) ? dt[DEN_W-1:0] : US_PER_S;
  assign div_num   = prod_mag[DIV_W-1:0] +
                     ((cmd.op == OP_DIV_ALLOW) ? '0 : {{(DIV_W-DEN_W){1'b0}}, div_den >> 1});
  assign div_start = (cmd.op == OP_DIV_PRED) || (cmd.op == OP_DIV_ALLOW) ||
                     (cmd.op == OP_DIV_RAW);

  togvf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign qs        = q_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign pred      = {{10{lp_sel[POS_W-1]}}, lp_sel} + qs[33:0];
  assign diff_full = {{10{m_sel[POS_W-1]}}, m_sel} - pred;

  // rounded shift by 16 and saturation
  assign acc_mag = acc[63] ? 64'(-acc) : 64'(acc);
  assign vmag    = (acc_mag + 64'd32768) >> 16;
  always_comb begin
    if (acc[63]) begin
      vnew = (vmag > 64'h80000000) ? 32'sh80000000 : $signed(-vmag[31:0]);
    end else begin
      vnew = (vmag > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(vmag[31:0]);
    end
  end

  assign status.ignore      = !valid || (t == '0) || (have && (t <= ltime));
  assign status.first       = !have;
  assign status.long_gap    = (dt >= {28'b0, US_PER_S});
  assign status.outlier     = (innov > {30'b0, prod[33:0]});
  assign status.below_limit = (rcnt < limit);
  assign status.div_busy    = div_busy;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      margin     <= 16'd1000;
      speed      <= 16'd2000;
      limit      <= 8'd3;
      alpha      <= 17'd32768;
      predict_ms <= 14'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MARGIN:  margin     <= cfg_data[15:0];
        REG_SPEED:   speed      <= cfg_data[15:0];
        REG_LIMIT:   limit      <= cfg_data[7:0];
        REG_ALPHA:   alpha      <= cfg_data;
        REG_PREDICT: predict_ms <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // target state
  always_ff @(posedge clk) begin
    if (rst) begin
      have  <= 1'b0;
      ltime <= '0;
      rcnt  <= '0;
      for (int i = 0; i < 3; i++) begin
        lp[i] <= '0;
        v[i]  <= '0;
      end
    end else begin
      unique case (cmd.op)
        OP_REJECT: rcnt <= rcnt + 1'b1;
        OP_VZERO: begin
          for (int i = 0; i < 3; i++) v[i] <= '0;
        end
        OP_VSET: v[cmd.axis] <= vnew;
        OP_ACCEPT: begin
          for (int i = 0; i < 3; i++) lp[i] <= m[i];
          ltime <= t;
          have  <= 1'b1;
          rcnt  <= '0;
        end
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
    if (div_start) q_neg <= prod[PROD_W-1];
    unique case (cmd.op)
      OP_LOAD: begin
        m[0]     <= meas_x_mm;
        m[1]     <= meas_y_mm;
        m[2]     <= meas_z_mm;
        t        <= meas_time_us;
        valid    <= meas_valid;
        innov    <= '0;
        acc_flag <= 1'b0;
        rej_flag <= 1'b0;
      end
      OP_DT:     dt    <= t - ltime;
      OP_AGE:    age   <= age_next;
      OP_PDIFF:  diff  <= diff_full[MUL_W-1:0];
      OP_SQACC:  innov <= innov + prod[63:0];
      OP_ASET:   allow <= {1'b0, margin} + quot[16:0];
      OP_REJECT: rej_flag <= 1'b1;
      OP_RSET:   raw   <= qs[47:0];
      OP_AHI:    acc   <= prod[63:0];
      OP_AOLD:   acc   <= acc + {prod[39:0], 24'b0};
      OP_ASUM:   acc   <= acc + prod[63:0];
      OP_ACCEPT: acc_flag <= 1'b1;
      OP_OUT: begin
        accepted         <= acc_flag;
        outlier_rejected <= rej_flag;
        rejects_in_row   <= rcnt;
        vel_x_mm_s       <= v[0];
        vel_y_mm_s       <= v[1];
        vel_z_mm_s       <= v[2];
      end
      default: ;
    endcase
  end

endmodule

/* rtl/togvf_ctrl.sv */
// controller: sequences the datapath for one word and runs both handshakes
module togvf_ctrl import togvf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DT     = 5'd1;
  localparam logic [4:0] S_DECIDE = 5'd2;
  localparam logic [4:0] S_PMUL   = 5'd3;
  localparam logic [4:0] S_PDIV   = 5'd4;
  localparam logic [4:0] S_PWAIT  = 5'd5;
  localparam logic [4:0] S_PDIFF  = 5'd6;
  localparam logic [4:0] S_SQ     = 5'd7;
  localparam logic [4:0] S_SQACC  = 5'd8;
  localparam logic [4:0] S_AMUL   = 5'd9;
  localparam logic [4:0] S_ADIV   = 5'd10;
  localparam logic [4:0] S_AWAIT  = 5'd11;
  localparam logic [4:0] S_ASET   = 5'd12;
  localparam logic [4:0] S_ASQ    = 5'd13;
  localparam logic [4:0] S_CMP    = 5'd14;
  localparam logic [4:0] S_RMUL   = 5'd15;
  localparam logic [4:0] S_RDIV   = 5'd16;
  localparam logic [4:0] S_RWAIT  = 5'd17;
  localparam logic [4:0] S_RSET   = 5'd18;
  localparam logic [4:0] S_ALO    = 5'd19;
  localparam logic [4:0] S_AHI    = 5'd20;
  localparam logic [4:0] S_AOLD   = 5'd21;
  localparam logic [4:0] S_ASUM   = 5'd22;
  localparam logic [4:0] S_VSET   = 5'd23;
  localparam logic [4:0] S_ACCEPT = 5'd24;
  localparam logic [4:0] S_OUT    = 5'd25;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] axis;
  logic [1:0] axis_next;
  logic       out_valid_next;
  logic       out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd.op     = OP_NONE;
    cmd.axis   = axis;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DT;
        end
      end
      S_DT: begin
        cmd.op     = OP_DT;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.op    = OP_AGE;
        axis_next = 2'd0;
        priority if (status.ignore) state_next = S_OUT;
        else if (status.first || status.long_gap) state_next = S_ACCEPT;
        else state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.op     = OP_PMUL;
        state_next = S_PDIV;
      end
      S_PDIV: begin
        cmd.op     = OP_DIV_PRED;
        state_next = S_PWAIT;
      end
      S_PWAIT: if (!status.div_busy) state_next = S_PDIFF;
      S_PDIFF: begin
        cmd.op     = OP_PDIFF;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op     = OP_SQ;
        state_next = S_SQACC;
      end
      S_SQACC: begin
        cmd.op = OP_SQACC;
        if (axis == 2'd2) begin
          axis_next  = 2'd0;
          state_next = S_AMUL;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_PMUL;
        end
      end
      S_AMUL: begin
        cmd.op     = OP_AMUL;
        state_next = S_ADIV;
      end
      S_ADIV: begin
        cmd.op     = OP_DIV_ALLOW;
        state_next = S_AWAIT;
      end
      S_AWAIT: if (!status.div_busy) state_next = S_ASET;
      S_ASET: begin
        cmd.op     = OP_ASET;
        state_next = S_ASQ;
      end
      S_ASQ: begin
        cmd.op     = OP_ASQ;
        state_next = S_CMP;
      end
      S_CMP: begin
        priority if (status.outlier && status.below_limit) begin
          cmd.op     = OP_REJECT;
          state_next = S_OUT;
        end else if (status.outlier) begin
          cmd.op     = OP_VZERO;
          state_next = S_ACCEPT;
        end else begin
          state_next = S_RMUL;
        end
      end
      S_RMUL: begin
        cmd.op     = OP_RMUL;
        state_next = S_RDIV;
      end
      S_RDIV: begin
        cmd.op     = OP_DIV_RAW;
        state_next = S_RWAIT;
      end
      S_RWAIT: if (!status.div_busy) state_next = S_RSET;
      S_RSET: begin
        cmd.op     = OP_RSET;
        state_next = S_ALO;
      end
      S_ALO: begin
        cmd.op     = OP_ALO;
        state_next = S_AHI;
      end
      S_AHI: begin
        cmd.op     = OP_AHI;
        state_next = S_AOLD;
      end
      S_AOLD: begin
        cmd.op     = OP_AOLD;
        state_next = S_ASUM;
      end
      S_ASUM: begin
        cmd.op     = OP_ASUM;
        state_next = S_VSET;
      end
      S_VSET: begin
        cmd.op = OP_VSET;
        if (axis == 2'd2) begin
          state_next = S_ACCEPT;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_RMUL;
        end
      end
      S_ACCEPT: begin
        cmd.op     = OP_ACCEPT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_ready) out_valid_next = 1'b0;
    if (out_load) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/target_outlier_gate_velocity_filter.sv */
// Target outlier gate and velocity filter, top level. One word is taken at a
// time. An ignored measurement goes straight to the output, and a first or
// long-gap one is accepted without the gate. A gated outlier is rejected, or
// accepted with zeroed velocity at the reject limit; a gated, plausible
// measurement runs the full velocity update.
// The shared divider retires four quotient bits a cycle. That is 13 steps
// for one division, and the full path has seven divisions. The 33x33
// multiplier is shared as well.
// A finished result sits in an output register. The next word is taken in
// the cycle after the result is loaded. A word whose result finds that
// register still full waits in its last step until the word there is read.
module target_outlier_gate_velocity_filter import togvf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] meas_x_mm,
  input  logic signed [POS_W-1:0] meas_y_mm,
  input  logic signed [POS_W-1:0] meas_z_mm,
  input  logic [TIME_W-1:0]       meas_time_us,
  input  logic                    meas_valid,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    accepted,
  output logic                    outlier_rejected,
  output logic [CNT_W-1:0]        rejects_in_row,
  output logic signed [VEL_W-1:0] vel_x_mm_s,
  output logic signed [VEL_W-1:0] vel_y_mm_s,
  output logic signed [VEL_W-1:0] vel_z_mm_s
);

  dp_cmd_t    cmd;
  dp_status_t status;

  togvf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  togvf_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .meas_x_mm        (meas_x_mm),
    .meas_y_mm        (meas_y_mm),
    .meas_z_mm        (meas_z_mm),
    .meas_time_us     (meas_time_us),
    .meas_valid       (meas_valid),
    .accepted         (accepted),
    .outlier_rejected (outlier_rejected),
    .rejects_in_row   (rejects_in_row),
    .vel_x_mm_s       (vel_x_mm_s),
    .vel_y_mm_s       (vel_y_mm_s),
    .vel_z_mm_s       (vel_z_mm_s)
  );

endmodule
